@@ hdl/word_hash_double_hash_insert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the word-hash document indexer
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WORD_HASH_DOUBLE_HASH_INSERT_MACROS_SVH
`define WORD_HASH_DOUBLE_HASH_INSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset
`define WHDH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs out of reset
`define WHDH_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define WHDH_ASSERT(lbl, prop, msg)
`define WHDH_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ hdl/whdh_pkg.sv @@
// ----------------------------------------------------------------------------
// whdh_pkg
// Types, codes and helpers shared by the word-hash document indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package whdh_pkg;

    // Input operation codes
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_READ     = 2'd2;

    // Configuration port
    localparam int         PADDR_W       = 3;
    localparam logic       REG_HASH_BASE = 1'b0;
    localparam logic [7:0] HASH_BASE_RST = 8'd31;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_H1,
        ST_MOD_STEP,
        ST_PROBE,
        ST_READ,
        ST_RESP
    } state_t;

    // One result item
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [3:0]  probe_count;
        logic [15:0] stored_id;
        logic        occupied;
        logic [31:0] doc_key;
    } res_t;

    // Whitespace: space, tab, line feed, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

@@ hdl/whdh_if.sv @@
// ----------------------------------------------------------------------------
// whdh_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface whdh_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  byte_in;
    logic [15:0] doc_id;
    logic [3:0]  slot_sel;

    modport source (output valid, output op, output byte_in, output doc_id,
                    output slot_sel, input ready);
    modport sink   (input valid, input op, input byte_in, input doc_id,
                    input slot_sel, output ready);
endinterface

interface whdh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [3:0]  probe_count;
    logic [15:0] stored_id;
    logic        occupied;
    logic [31:0] doc_key;

    modport source (output valid, output status, output slot, output probe_count,
                    output stored_id, output occupied, output doc_key, input ready);
    modport sink   (input valid, input status, input slot, input probe_count,
                    input stored_id, input occupied, input doc_key, output ready);
endinterface

`default_nettype wire

@@ hdl/whdh_ram.sv @@
// ----------------------------------------------------------------------------
// whdh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module whdh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 11
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, held when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/word_hash_double_hash_insert.sv @@
// ----------------------------------------------------------------------------
// word_hash_double_hash_insert
// Document byte: taken while idle, next item taken the cycle after.
// Read slot: RAM read at the transfer, result built in ST_READ, output register loaded in ST_RESP.
// Insert: key mod TABLE_SLOTS and mod TABLE_SLOTS-1 by reciprocal multiply on one
//   shared multiplier, each as a quotient phase then a remainder phase, then the
//   probe walk on the compare-subtract unit, then the output register; a result still
//   waiting in the output register holds the sequencer until it is taken.
// Reset (rst_n, async): hash_base 31, word state cleared, table empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "word_hash_double_hash_insert_macros.svh"

module word_hash_double_hash_insert
    import whdh_pkg::*;
#(
    parameter int TABLE_SLOTS = 11
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    whdh_in_if.sink                 in_ch,
    whdh_out_if.source              out_ch
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int RW    = IDX_W + 1;

    // Reciprocal constants: floor(2^sh / d) + 1 gives the exact quotient of
    // any 32-bit key when sh = 32 + ceil(log2(d))
    localparam int          SH_H1      = 32 + $clog2(TABLE_SLOTS);
    localparam int          SH_STEP    = 32 + $clog2(TABLE_SLOTS - 1);
    localparam logic [32:0] MAGIC_H1   =
        33'((64'd1 << SH_H1) / 64'(TABLE_SLOTS) + 64'd1);
    localparam logic [32:0] MAGIC_STEP =
        33'((64'd1 << SH_STEP) / 64'(TABLE_SLOTS - 1) + 64'd1);

    // Control state
    state_t                 state_reg, state_next;
    logic [7:0]             base_reg, base_next;
    logic [31:0]            word_hash_reg, word_hash_next;
    logic [31:0]            doc_key_reg, doc_key_next;
    logic                   in_word_reg, in_word_next;
    logic [TABLE_SLOTS-1:0] used_reg, used_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   phase_reg, phase_next;

    // Payload
    logic [31:0]            key_reg, key_next;
    logic [31:0]            quot_reg, quot_next;
    logic [IDX_W-1:0]       h1_reg, h1_next;
    logic [IDX_W-1:0]       step_reg, step_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic [15:0]            id_reg, id_next;
    logic [3:0]             sel_reg, sel_next;
    logic                   sel_hit_reg, sel_hit_next;
    res_t                   res_reg, res_next;
    res_t                   out_reg, out_next;

    // Compare-subtract unit of the probe walk
    logic [RW-1:0]          unit_a, unit_m, unit_y;
    logic [IDX_W-1:0]       unit_r;

    // Shared reciprocal multiplier
    logic [32:0]            mul_magic;
    logic [64:0]            mul_prod;
    logic [31:0]            mul_quot;
    logic [31:0]            mod_rem;

    // RAM port and handshake helpers
    logic                   ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [15:0]            ram_rd_data;
    logic                   in_xfer, out_free, cfg_wr;
    logic [31:0]            insert_key;
    logic                   sel_in_range;

    whdh_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_SLOTS)
    ) u_ids (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (id_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_HASH_BASE);
    assign prdata = (paddr[PADDR_W-1] == REG_HASH_BASE) ? {24'd0, base_reg} : 32'd0;

    // Handshake helpers
    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign insert_key   = doc_key_reg + (in_word_reg ? word_hash_reg : 32'd0);
    assign sel_in_range = 32'(in_ch.slot_sel) < 32'(TABLE_SLOTS);

    // Compare-subtract unit: one conditional subtract of the modulus for the probe walk
    always_comb
    begin
        unit_a = RW'({1'b0, pos_reg}) + RW'({1'b0, step_reg});
        unit_m = RW'(TABLE_SLOTS);
        unit_y = (unit_a >= unit_m) ? (unit_a - unit_m) : unit_a;
        unit_r = unit_y[IDX_W-1:0];
    end

    // Shared multiplier: quotient of the key, then the remainder from it
    always_comb
    begin
        mul_magic = (state_reg == ST_MOD_STEP) ? MAGIC_STEP : MAGIC_H1;
        mul_prod  = {33'd0, key_reg} * {32'd0, mul_magic};
        if (state_reg == ST_MOD_STEP)
        begin
            mul_quot = 32'(mul_prod >> SH_STEP);
            mod_rem  = key_reg - 32'(quot_reg * 32'(TABLE_SLOTS - 1));
        end
        else
        begin
            mul_quot = 32'(mul_prod >> SH_H1);
            mod_rem  = key_reg - 32'(quot_reg * 32'(TABLE_SLOTS));
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && in_ch.op == OP_INSERT)
                begin
                    state_next = ST_MOD_H1;
                end
                else if (in_xfer && in_ch.op == OP_READ)
                begin
                    state_next = ST_READ;
                end
            end
            ST_MOD_H1:
            begin
                if (phase_reg)
                begin
                    state_next = ST_MOD_STEP;
                end
            end
            ST_MOD_STEP:
            begin
                if (phase_reg)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (!used_reg[pos_reg] || cnt_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and RAM control outputs
    always_comb
    begin
        in_ch.ready = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_addr = IDX_W'(in_ch.slot_sel);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                ram_rd_en   = in_ch.valid && in_ch.op == OP_READ;
            end
            ST_PROBE:
            begin
                ram_wr_en = !used_reg[pos_reg];
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        base_next      = cfg_wr ? pwdata[7:0] : base_reg;
        word_hash_next = word_hash_reg;
        doc_key_next   = doc_key_reg;
        in_word_next   = in_word_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        phase_next     = phase_reg;
        key_next       = key_reg;
        quot_next      = quot_reg;
        h1_next        = h1_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        id_next        = id_reg;
        sel_next       = sel_reg;
        sel_hit_next   = sel_hit_reg;
        res_next       = res_reg;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (in_ch.op)
                        OP_BYTE:
                        begin
                            // Close a word on whitespace, else advance its hash
                            if (is_space(in_ch.byte_in))
                            begin
                                doc_key_next   = insert_key;
                                word_hash_next = 32'd0;
                                in_word_next   = 1'b0;
                            end
                            else
                            begin
                                word_hash_next = 32'(word_hash_reg * 32'(base_reg))
                                               + 32'(in_ch.byte_in);
                                in_word_next   = 1'b1;
                            end
                        end
                        OP_INSERT:
                        begin
                            // Latch the key and start the mod pass
                            key_next       = insert_key;
                            id_next        = in_ch.doc_id;
                            phase_next     = 1'b0;
                            word_hash_next = 32'd0;
                            doc_key_next   = 32'd0;
                            in_word_next   = 1'b0;
                        end
                        OP_READ:
                        begin
                            sel_next     = in_ch.slot_sel;
                            sel_hit_next = sel_in_range && used_reg[IDX_W'(in_ch.slot_sel)];
                        end
                        default:
                        begin
                            sel_next = sel_reg;
                        end
                    endcase
                end
            end
            ST_MOD_H1:
            begin
                // Quotient by TABLE_SLOTS, then the home slot from it
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    quot_next = mul_quot;
                end
                else
                begin
                    h1_next = mod_rem[IDX_W-1:0];
                end
            end
            ST_MOD_STEP:
            begin
                // Same pass by TABLE_SLOTS-1 for the probe step
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    quot_next = mul_quot;
                end
                else
                begin
                    step_next = mod_rem[IDX_W-1:0] + IDX_W'(1);
                    pos_next  = h1_reg;
                    cnt_next  = '0;
                end
            end
            ST_PROBE:
            begin
                if (!used_reg[pos_reg])
                begin
                    // Take the free slot
                    used_next[pos_reg]   = 1'b1;
                    res_next.status      = STATUS_INSERTED;
                    res_next.slot        = 4'(pos_reg);
                    res_next.probe_count = 4'(cnt_reg);
                    res_next.stored_id   = id_reg;
                    res_next.occupied    = 1'b1;
                    res_next.doc_key     = key_reg;
                end
                else if (cnt_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    // Every slot visited and occupied
                    res_next.status      = STATUS_FULL;
                    res_next.slot        = 4'd0;
                    res_next.probe_count = 4'(TABLE_SLOTS);
                    res_next.stored_id   = 16'd0;
                    res_next.occupied    = 1'b0;
                    res_next.doc_key     = key_reg;
                end
                else
                begin
                    pos_next = unit_r;
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_READ:
            begin
                res_next.status      = STATUS_READ;
                res_next.slot        = sel_reg;
                res_next.probe_count = 4'd0;
                res_next.stored_id   = sel_hit_reg ? ram_rd_data : 16'd0;
                res_next.occupied    = sel_hit_reg;
                res_next.doc_key     = 32'd0;
            end
            ST_RESP:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= HASH_BASE_RST;
            word_hash_reg <= 32'd0;
            doc_key_reg   <= 32'd0;
            in_word_reg   <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            word_hash_reg <= word_hash_next;
            doc_key_reg   <= doc_key_next;
            in_word_reg   <= in_word_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        quot_reg    <= quot_next;
        h1_reg      <= h1_next;
        step_reg    <= step_next;
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        id_reg      <= id_next;
        sel_reg     <= sel_next;
        sel_hit_reg <= sel_hit_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    // Output channel
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_reg.status;
    assign out_ch.slot        = out_reg.slot;
    assign out_ch.probe_count = out_reg.probe_count;
    assign out_ch.stored_id   = out_reg.stored_id;
    assign out_ch.occupied    = out_reg.occupied;
    assign out_ch.doc_key     = out_reg.doc_key;

    // Checks
    `WHDH_ASSERT(a_probe_pos, state_reg == ST_PROBE |-> 32'(pos_reg) < 32'(TABLE_SLOTS), "probe position out of table")
    `WHDH_ASSERT(a_probe_cnt, state_reg == ST_PROBE |-> 32'(cnt_reg) < 32'(TABLE_SLOTS), "probe count past table size")
    `WHDH_ASSERT_NEVER(a_step_zero, state_reg == ST_PROBE && step_reg == '0, "zero probe step")
    `WHDH_ASSERT(a_full_all_used, state_reg == ST_RESP && res_reg.status == STATUS_FULL |-> &used_reg, "full reported with a free slot")

endmodule

`default_nettype wire
